>>> hdl/sha_pkg.sv
`default_nettype none
package sha_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 61;
  localparam int unsigned Rounds = 64;
  localparam logic [7:0]  PadMark = 8'h80;
  localparam logic [5:0]  LenPos  = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOADV,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_byte;
    logic pad_start;
    logic pad_byte;
    logic load_v;
    logic round;
    logic add;
    logic out_next;
    logic finish;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic blk_full;
    logic pad_wrap;
    logic len_done;
    logic rnd_last;
    logic out_last;
  } stat_t;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] idx);
    logic [31:0] h;
    unique case (idx)
      3'd0: h = 32'h6a09e667;
      3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372;
      3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f;
      3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_s0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_s1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage
`default_nettype wire

>>> hdl/sha_ctrl.sv
`default_nettype none
module sha_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          byte_valid,
  input  wire logic          last,
  input  wire logic          out_ready,
  input  wire sha_pkg::stat_t stat,
  output sha_pkg::cmd_t      cmd,
  output logic               in_ready,
  output logic               out_valid
);

  sha_pkg::state_t state, state_next;
  logic pad_mode, pad_mode_next;
  logic in_acc;

  assign in_acc = in_valid && (state == sha_pkg::ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sha_pkg::ST_IDLE;
      pad_mode <= 1'b0;
    end else begin
      state    <= state_next;
      pad_mode <= pad_mode_next;
    end
  end

  // next state
  always_comb begin
    state_next    = state;
    pad_mode_next = pad_mode;
    unique case (state)
      sha_pkg::ST_IDLE: begin
        if (in_acc) begin
          pad_mode_next = last;
          if (byte_valid && stat.blk_full) state_next = sha_pkg::ST_LOADV;
          else if (last)                   state_next = sha_pkg::ST_PAD;
        end
      end
      sha_pkg::ST_PAD: begin
        if (stat.pad_wrap) state_next = sha_pkg::ST_LOADV;
      end
      sha_pkg::ST_LOADV: state_next = sha_pkg::ST_ROUND;
      sha_pkg::ST_ROUND: begin
        if (stat.rnd_last) state_next = sha_pkg::ST_ADD;
      end
      sha_pkg::ST_ADD: begin
        if (!pad_mode)          state_next = sha_pkg::ST_IDLE;
        else if (stat.len_done) state_next = sha_pkg::ST_OUT;
        else                    state_next = sha_pkg::ST_PAD;
      end
      sha_pkg::ST_OUT: begin
        if (out_ready && stat.out_last) begin
          state_next    = sha_pkg::ST_IDLE;
          pad_mode_next = 1'b0;
        end
      end
      default: state_next = sha_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      sha_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_byte = in_acc && byte_valid;
        cmd.pad_start = in_acc && last;
      end
      sha_pkg::ST_PAD:   cmd.pad_byte = 1'b1;
      sha_pkg::ST_LOADV: cmd.load_v   = 1'b1;
      sha_pkg::ST_ROUND: cmd.round    = 1'b1;
      sha_pkg::ST_ADD:   cmd.add      = 1'b1;
      sha_pkg::ST_OUT: begin
        out_valid    = 1'b1;
        cmd.out_next = out_ready;
        cmd.finish   = out_ready && stat.out_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/sha_dp.sv
`default_nettype none
module sha_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire sha_pkg::cmd_t cmd,
  input  wire logic [7:0]    data_byte,
  output sha_pkg::stat_t     stat,
  output logic [31:0]        digest_word,
  output logic [2:0]         word_index,
  output logic               last_word
);

  logic [511:0] win;
  logic [sha_pkg::CountW-1:0] count, count_inc;
  logic [63:0] len_sr;
  logic [5:0]  pidx, rnd;
  logic        first, final_blk, len_done;
  logic [2:0]  oidx;
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [7:0]  pad_val;
  logic [31:0] w0, w1, w9, w14, w_new, t1, t2;

  assign count_inc = count + 1'b1;
  assign w0  = win[511:480];
  assign w1  = win[479:448];
  assign w9  = win[223:192];
  assign w14 = win[63:32];
  assign w_new = sha_pkg::sml_s1(w14) + w9 + sha_pkg::sml_s0(w1) + w0;
  assign t1 = v[7] + sha_pkg::big_s1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + sha_pkg::round_k(rnd) + w0;
  assign t2 = sha_pkg::big_s0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  // padding byte select
  always_comb begin
    if (first)                                pad_val = sha_pkg::PadMark;
    else if (final_blk && pidx >= sha_pkg::LenPos) pad_val = len_sr[63:56];
    else                                      pad_val = 8'h00;
  end

  // message window: byte shift on load and padding, word shift on rounds
  always_ff @(posedge clk) begin
    if (cmd.load_byte)     win <= {win[503:0], data_byte};
    else if (cmd.pad_byte) win <= {win[503:0], pad_val};
    else if (cmd.round)    win <= {win[479:0], w_new};
  end

  // byte count
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) count <= '0;
    else if (cmd.load_byte) count <= count_inc;
  end

  // padding control
  always_ff @(posedge clk) begin
    if (rst) begin
      first     <= 1'b0;
      final_blk <= 1'b0;
      len_done  <= 1'b0;
      pidx      <= '0;
    end else if (cmd.pad_start) begin
      first    <= 1'b1;
      len_done <= 1'b0;
      if (cmd.load_byte) begin
        pidx      <= count_inc[5:0];
        final_blk <= (count_inc[5:0] < sha_pkg::LenPos);
      end else begin
        pidx      <= count[5:0];
        final_blk <= (count[5:0] < sha_pkg::LenPos);
      end
    end else if (cmd.pad_byte) begin
      first <= 1'b0;
      pidx  <= pidx + 1'b1;
      if (pidx == 6'd63) begin
        if (final_blk) len_done <= 1'b1;
        final_blk <= 1'b1;
      end
    end
  end

  // length shifter
  always_ff @(posedge clk) begin
    if (cmd.pad_start) begin
      if (cmd.load_byte) len_sr <= {count_inc, 3'b000};
      else               len_sr <= {count, 3'b000};
    end else if (cmd.pad_byte && !first && final_blk && pidx >= sha_pkg::LenPos) begin
      len_sr <= {len_sr[55:0], 8'h00};
    end
  end

  // round counter and working variables
  always_ff @(posedge clk) begin
    if (cmd.load_v) begin
      rnd <= '0;
      for (int i = 0; i < 8; i++) v[i] <= h[i];
    end else if (cmd.round) begin
      rnd  <= rnd + 1'b1;
      v[0] <= t1 + t2;
      v[1] <= v[0];
      v[2] <= v[1];
      v[3] <= v[2];
      v[4] <= v[3] + t1;
      v[5] <= v[4];
      v[6] <= v[5];
      v[7] <= v[6];
    end
  end

  // chaining value
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      for (int i = 0; i < 8; i++) h[i] <= sha_pkg::init_h(3'(i));
    end else if (cmd.add) begin
      for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
    end
  end

  // digest word counter
  always_ff @(posedge clk) begin
    if (rst) oidx <= '0;
    else if (cmd.out_next) oidx <= oidx + 1'b1;
  end

  assign digest_word = h[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd7);

  assign stat.blk_full = (count_inc[5:0] == 6'd0);
  assign stat.pad_wrap = cmd.pad_byte && (pidx == 6'd63);
  assign stat.len_done = len_done;
  assign stat.rnd_last = (rnd == 6'(sha_pkg::Rounds - 1));
  assign stat.out_last = (oidx == 3'd7);

endmodule
`default_nettype wire

>>> hdl/sha256_stream_hasher_top.sv
`default_nettype none
// sha-256 hasher over a byte stream
// input channel: one request per item carries data_byte, byte_valid and last;
// a request with byte_valid low only matters when last is high.
// output channel: eight requests per message, digest_word with word_index 0
// (most significant) to 7, last_word high on the eighth.
// a request without a block boundary or last keeps the input open.
// every 64th byte starts a compression (load, 64 rounds of one
// shared round unit, add); input is held off meanwhile.
// on last the padding bytes are shifted in one per cycle (9 to 64 in one
// block, or 65 to 72 over two blocks when the length needs an extra block),
// each full block compressed (padding waits meanwhile), then the digest
// is offered.
// a receiver stall holds the current digest word; no new input is taken
// until the eighth word has been taken, after which the hash state returns
// to the initial values.
// reset clears the count, loads the initial hash values and idles.
module sha256_stream_hasher_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_valid,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);

  sha_pkg::cmd_t  cmd;
  sha_pkg::stat_t stat;

  sha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .byte_valid (byte_valid),
    .last       (last),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd),
    .in_ready   (in_ready),
    .out_valid  (out_valid)
  );

  sha_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .stat        (stat),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
  );

`ifndef ASSERT_OFF
  // input and output never both open
  a_excl: assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input open while digest pending");

  // input request without last never yields output next cycle
  a_nolast: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !last) |=> !out_valid)
    else $error("digest without last");

  // after the eighth word the block idles
  a_ret: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_word) |=> in_ready)
    else $error("no return to idle after digest");

  // a taken word other than the last is followed by a valid word with nonzero index
  a_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_word) |=> (out_valid && word_index != 3'd0))
    else $error("digest word order broken");
`endif

endmodule
`default_nettype wire

>>> bench/sha256_digest_checker.sv
`timescale 1ns / 100ps
module sha256_digest_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_valid,
  input  wire logic        last,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] digest_word,
  input  wire logic [2:0]  word_index,
  input  wire logic        last_word,
  output int               fail_count,
  output int               pending_words
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        lst;
  } digest_item_t;

  logic [31:0]  hash_state [8];
  logic [7:0]   msg_block [64];
  logic [60:0]  msg_len;
  digest_item_t digest_queue [$];

  assign pending_words = digest_queue.size();

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] kconst(input int t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  task automatic load_iv();
    hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                   32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  endtask

  // one 64-round compression of msg_block into hash_state
  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
             (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    v = hash_state;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(t) + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int t = 0; t < 8; t++) hash_state[t] += v[t];
  endtask

  // absorb one request, queue the digest when the message ends
  task automatic absorb(input logic [7:0] b, input logic bv, input logic fin);
    logic [63:0] bits;
    int pos;
    if (bv) begin
      msg_block[msg_len[5:0]] = b;
      msg_len = msg_len + 61'd1;
      if (msg_len[5:0] == 6'd0) compress();
    end
    if (fin) begin
      bits = {msg_len, 3'b000};
      pos = msg_len[5:0];
      msg_block[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        while (pos < 64) msg_block[pos++] = 8'h00;
        compress();
        pos = 0;
      end
      while (pos < 56) msg_block[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++)
        digest_queue.push_back('{hash_state[i], 3'(i), i == 7});
      load_iv();
      msg_len = '0;
    end
  endtask

  // watch both channels
  always @(posedge clk) begin
    digest_item_t exp_item;
    if (rst) begin
      load_iv();
      msg_len = '0;
      digest_queue.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) absorb(data_byte, byte_valid, last);
      if (out_valid && out_ready) begin
        if (digest_queue.size() == 0) begin
          $error("digest_word %h with no digest pending", digest_word);
          fail_count++;
        end else begin
          exp_item = digest_queue.pop_front();
          if (digest_word !== exp_item.word) begin
            $error("digest_word expected %h actual %h", exp_item.word, digest_word);
            fail_count++;
          end
          if (word_index !== exp_item.idx) begin
            $error("word_index expected %0d actual %0d", exp_item.idx, word_index);
            fail_count++;
          end
          if (last_word !== exp_item.lst) begin
            $error("last_word expected %0d actual %0d", exp_item.lst, last_word);
            fail_count++;
          end
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

>>> bench/sha256_stream_hasher_top_tb.sv
`timescale 1ns / 100ps
module sha256_stream_hasher_top_tb;

  localparam int IdleLimit = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        byte_valid = 1'b0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int          fail_count;
  int          pending_words;
  int          idle_cycles = 0;
  bit          stall_on = 1'b1;

  always #5 clk = ~clk;

  sha256_stream_hasher_top u_top (.*);

  sha256_digest_checker u_checker (.*);

  // receiver stall pattern
  always @(posedge clk) begin
    if (!stall_on) out_ready <= 1'b1;
    else if ($urandom_range(0, 3) == 0) out_ready <= ($urandom_range(0, 4) != 0);
  end

  // watchdog on cycles with no accepted request
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // send one request and wait for acceptance
  task automatic send_request(input logic [7:0] b, input logic bv, input logic fin);
    in_valid   <= 1'b1;
    data_byte  <= b;
    byte_valid <= bv;
    last       <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic pause_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // message of n bytes with random content, optional empty terminator
  task automatic send_message(input int n, input bit burst);
    bit sep;
    sep = (n == 0) || ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      if (!burst && $urandom_range(0, 5) == 0) pause_sender();
      if ($urandom_range(0, 9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, !sep && i == n - 1);
    end
    if (sep) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // directed: empty message, extremes, padding boundaries
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'h5a, 1'b0, 1'b0);
    send_request(8'ha5, 1'b1, 1'b1);
    send_message(56, 1'b1);
    send_message(64, 1'b1);
    // random short messages, some in bursts
    n = 130;
    while (n < 160) begin
      int len;
      len = $urandom_range(0, 12);
      stall_on = ($urandom_range(0, 3) != 0);
      send_message(len, $urandom_range(0, 2) == 0);
      n += len + 1;
      if ($urandom_range(0, 1)) pause_sender();
    end
    in_valid <= 1'b0;
    while (pending_words != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
